### hdl/drp_pkg.sv
// Shared types and constants for the droplet ramp envelope.
package drp_pkg;

    localparam int ACTION_W = 2;
    localparam int LEN_W    = 32;
    localparam int POS_W    = 40;
    localparam int END_W    = 36;
    localparam int ALU_W    = 43;
    localparam int LEVEL_W  = 17;
    localparam int QUOT_W   = 17;
    localparam int REM_W    = 33;
    localparam int STEP_W   = 5;
    localparam int IN_W     = 104;
    localparam int OUT_W    = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [STEP_W-1:0]  DIV_LAST   = STEP_W'(QUOT_W - 1);
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(65536);

    localparam logic signed [ALU_W-1:0] POS_MAX = ALU_W'(64'sd549755813887);
    localparam logic signed [ALU_W-1:0] POS_MIN = -ALU_W'(64'sd549755813888);

    typedef enum logic [ACTION_W-1:0] {
        ACT_START  = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_SAMPLE = 2'd2,
        ACT_NONE   = 2'd3
    } drp_action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INIT_VELOCITY  = 2'd0,
        REG_ACCEL_PER_STEP = 2'd1,
        REG_HEAD_RAMP_LEN  = 2'd2,
        REG_HEAD_LEN       = 2'd3
    } drp_reg_t;

    typedef struct packed {
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
        logic                    sub;
    } drp_alu_op_t;

    typedef struct packed {
        logic signed [ALU_W-1:0] sum;
        logic signed [POS_W-1:0] sat;
        logic                    neg;
    } drp_alu_res_t;

endpackage

### hdl/drp_alu.sv
// Shared add/subtract unit with 40-bit signed saturation.
module drp_alu
    import drp_pkg::*;
(
    input  drp_alu_op_t  op,
    output drp_alu_res_t res
);

    logic signed [ALU_W-1:0] sum;

    assign sum = op.sub ? (op.a - op.b) : (op.a + op.b);

    always_comb
    begin
        res.sum = sum;
        res.neg = sum[ALU_W-1];
        priority if (sum > POS_MAX)
        begin
            res.sat = POS_MAX[POS_W-1:0];
        end
        else if (sum < POS_MIN)
        begin
            res.sat = POS_MIN[POS_W-1:0];
        end
        else
        begin
            res.sat = sum[POS_W-1:0];
        end
    end

endmodule

### hdl/droplet_ramp_envelope.sv
// Top level of the droplet ramp envelope: sequencer around one shared adder.
//
// Input stream s_*: one transfer carries an action (start, tick, sample) with
// travel distance, tail length and sample offset. Every input transfer gives
// exactly one output transfer on m_*: level, running flag and done pulse.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 init_velocity, 1 accel_per_step, 2 head_ramp_len, 3 head_len).
// All arithmetic runs through one 43-bit add/subtract unit, one operation per
// cycle. Steps per item up to the output register: start S_END1-3, tick S_T1-3,
//   sample S_P1-6 as needed, maybe then a 17-bit restoring division (one
//   quotient bit per cycle); none, or tick and sample while inactive: S_OUT.
// s_tready is high only while the sequencer is idle, so one item is in work
// at a time and the next item is taken in the cycle after the output register
// loads at the earliest; it may be taken while the last result still waits.
// If the receiver stalls, the finished result holds in the output register
// and the sequencer waits before loading the next one.
// Reset clears the droplet (inactive, no done pulse, position and velocity
// zero) and loads the register defaults; no output is pending.
module droplet_ramp_envelope
    import drp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // action[1:0], travel_dist[33:2], tail_len[65:34], offset[97:66], zero pad
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // level[16:0], running[17], finished[18], zero pad
    output logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_END1, S_END2, S_END3,
        S_T1, S_T2, S_T3,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6,
        S_DIV, S_OUT
    } state_t;

    state_t state_reg;

    logic [LEN_W-1:0]        init_vel_reg, accel_reg, ramp_reg, head_reg;
    logic                    run_reg, done_reg;
    logic signed [POS_W-1:0] pos_reg, vel_reg;
    logic [END_W-1:0]        end_reg;
    logic [LEN_W-1:0]        tail_reg;

    logic [LEN_W-1:0]        arg_reg;      // travel distance or offset
    logic signed [ALU_W-1:0] acc_reg;
    logic signed [ALU_W-1:0] rh_reg;       // leading edge minus offset
    logic [LEN_W+1:0]        hr_reg;       // ramp plus head
    logic [REM_W-1:0]        rem_reg;
    logic [LEN_W-1:0]        div_reg;
    logic [QUOT_W-1:0]       quot_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [LEVEL_W-1:0]      level_reg;

    logic                    m_valid_reg;
    logic [LEVEL_W-1:0]      out_level_reg;
    logic                    out_run_reg, out_done_reg;

    drp_action_t             in_action;
    logic [LEN_W-1:0]        in_travel, in_tail, in_offset;
    drp_alu_op_t             op;
    drp_alu_res_t            res;
    logic [REM_W:0]          div_a;
    logic [QUOT_W-1:0]       quot_next;
    logic                    out_load;

    assign in_action = drp_action_t'(s_tdata[1:0]);
    assign in_travel = s_tdata[33:2];
    assign in_tail   = s_tdata[65:34];
    assign in_offset = s_tdata[97:66];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, out_done_reg, out_run_reg, out_level_reg};

    // load the output register once it is free or being emptied
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_tready);

    // first division step compares the bare remainder, later ones shift it
    assign div_a     = (step_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign quot_next = {quot_reg[QUOT_W-2:0], !res.neg};

    always_comb
    begin
        op.a   = acc_reg;
        op.b   = '0;
        op.sub = 1'b0;
        unique case (state_reg)
            S_END1:
            begin
                op.a = ALU_W'(arg_reg);
                op.b = ALU_W'(ramp_reg);
            end
            S_END2: op.b = ALU_W'(head_reg);
            S_END3: op.b = ALU_W'(tail_reg);
            S_T1:
            begin
                op.a = ALU_W'(pos_reg);
                op.b = ALU_W'(vel_reg);
            end
            S_T2:
            begin
                op.a = ALU_W'(vel_reg);
                op.b = ALU_W'($signed(accel_reg));
            end
            S_T3:
            begin
                op.a   = ALU_W'(pos_reg);
                op.b   = ALU_W'(end_reg);
                op.sub = 1'b1;
            end
            S_P1:
            begin
                op.a   = ALU_W'(pos_reg);
                op.b   = ALU_W'($signed(arg_reg));
                op.sub = 1'b1;
            end
            S_P2:
            begin
                op.a = ALU_W'(ramp_reg);
                op.b = ALU_W'(head_reg);
            end
            S_P3:
            begin
                op.a = ALU_W'(hr_reg);
                op.b = ALU_W'(tail_reg);
            end
            S_P4:
            begin
                op.b   = rh_reg;
                op.sub = 1'b1;
            end
            S_P5:
            begin
                op.a   = rh_reg;
                op.b   = ALU_W'(ramp_reg);
                op.sub = 1'b1;
            end
            S_P6:
            begin
                op.a   = rh_reg;
                op.b   = ALU_W'(hr_reg);
                op.sub = 1'b1;
            end
            S_DIV:
            begin
                op.a   = ALU_W'(div_a);
                op.b   = ALU_W'(div_reg);
                op.sub = 1'b1;
            end
            S_IDLE, S_OUT:
            begin
                op.sub = 1'b0;
            end
        endcase
    end

    drp_alu u_alu (
        .op  (op),
        .res (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            init_vel_reg  <= LEN_W'(65536);
            accel_reg     <= '0;
            ramp_reg      <= LEN_W'(65536);
            head_reg      <= LEN_W'(65536);
            run_reg       <= 1'b0;
            done_reg      <= 1'b0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            end_reg       <= '0;
            tail_reg      <= LEN_W'(1);
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (drp_reg_t'(cfg_index))
                    REG_INIT_VELOCITY:  init_vel_reg <= cfg_data;
                    REG_ACCEL_PER_STEP: accel_reg    <= cfg_data;
                    REG_HEAD_RAMP_LEN:  ramp_reg     <= cfg_data;
                    REG_HEAD_LEN:       head_reg     <= cfg_data;
                endcase
            end

            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        level_reg <= '0;
                        unique case (in_action)
                            ACT_START:
                            begin
                                arg_reg  <= in_travel;
                                tail_reg <= (in_tail == '0) ? LEN_W'(1) : in_tail;
                                state_reg <= S_END1;
                            end
                            ACT_TICK:   state_reg <= run_reg ? S_T1 : S_OUT;
                            ACT_SAMPLE:
                            begin
                                arg_reg   <= in_offset;
                                state_reg <= run_reg ? S_P1 : S_OUT;
                            end
                            ACT_NONE:   state_reg <= S_OUT;
                        endcase
                    end
                end
                S_END1:
                begin
                    acc_reg   <= res.sum;
                    state_reg <= S_END2;
                end
                S_END2:
                begin
                    acc_reg   <= res.sum;
                    state_reg <= S_END3;
                end
                S_END3:
                begin
                    end_reg   <= res.sum[END_W-1:0];
                    pos_reg   <= '0;
                    vel_reg   <= POS_W'($signed(init_vel_reg));
                    done_reg  <= 1'b0;
                    run_reg   <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_T1:
                begin
                    pos_reg   <= res.sat;
                    state_reg <= S_T2;
                end
                S_T2:
                begin
                    vel_reg   <= res.sat;
                    state_reg <= S_T3;
                end
                S_T3:
                begin
                    // reached the end position: stop and raise the done pulse
                    if (!res.neg)
                    begin
                        done_reg <= 1'b1;
                        run_reg  <= 1'b0;
                    end
                    state_reg <= S_OUT;
                end
                S_P1:
                begin
                    rh_reg    <= res.sum;
                    state_reg <= S_P2;
                end
                S_P2:
                begin
                    hr_reg <= res.sum[LEN_W+1:0];
                    if (rh_reg[ALU_W-1] || (rh_reg == '0) || arg_reg[LEN_W-1])
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_P3;
                    end
                end
                S_P3:
                begin
                    acc_reg   <= res.sum;
                    state_reg <= S_P4;
                end
                S_P4:
                begin
                    // tail end lies beyond the offset
                    rem_reg <= res.sum[REM_W-1:0];
                    state_reg <= res.neg ? S_OUT : S_P5;
                end
                S_P5:
                begin
                    step_reg <= '0;
                    quot_reg <= '0;
                    if (res.neg)
                    begin
                        rem_reg   <= rh_reg[REM_W-1:0];
                        div_reg   <= ramp_reg;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_P6;
                    end
                end
                S_P6:
                begin
                    if (res.neg)
                    begin
                        level_reg <= FULL_LEVEL;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        div_reg   <= tail_reg;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg  <= res.neg ? div_a[REM_W-1:0] : res.sum[REM_W-1:0];
                    quot_reg <= quot_next;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == DIV_LAST)
                    begin
                        level_reg <= quot_next;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_level_reg <= level_reg;
                        out_run_reg   <= run_reg;
                        out_done_reg  <= done_reg;
                        done_reg      <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

### hdl/drp_chk.sv
// Port-level checks for the droplet ramp envelope, bound to the top level.
module drp_chk
    import drp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [IN_W-1:0]      s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_W-1:0]     m_tdata,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [LEN_W-1:0]     cfg_data
);

    // an accepted item keeps the sequencer busy in the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while previous item in work");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16:0] <= FULL_LEVEL))
        else $error("level above full scale");

    // the done pulse is only raised as the droplet stops
    a_done_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[17] && m_tdata[18]))
        else $error("done pulse while droplet running");

    a_lit_only_running: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[16:0] != '0)) |-> m_tdata[17])
        else $error("nonzero level from inactive droplet");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind droplet_ramp_envelope drp_chk u_drp_chk (.*);
